FILE: rtl/core/plns_pkg.sv
// Shared types, constants and sizes for the penalized nearest level search unit.
`default_nettype none
package plns_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int NUM_CELLS   = 8;
	localparam int BANK_DEPTH  = TABLE_DEPTH / NUM_CELLS;

	localparam int IDX_W    = 10;
	localparam int LEVEL_W  = 16;
	localparam int COST_W   = 16;
	localparam int VALUE_W  = 16;
	localparam int WEIGHT_W = 24;
	localparam int PEN_W    = 16;
	localparam int LIU_W    = 11;
	localparam int RES_W    = 17;
	localparam int SCORE_W  = 48;

	localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
	localparam int TIDX_W   = $clog2(TABLE_DEPTH);
	localparam int BANK_W   = $clog2(BANK_DEPTH);
	localparam int BCNT_W   = $clog2(BANK_DEPTH + 1);
	localparam int CELL_W   = $clog2(NUM_CELLS);

	localparam int ABS_W    = LEVEL_W;
	localparam int SQ_W     = 2 * ABS_W;
	localparam int PROD_W   = SQ_W + WEIGHT_W;
	localparam int PENP_W   = PEN_W + COST_W;
	localparam int PEN_SH   = 8;
	localparam int SUM_W    = PROD_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = WEIGHT_W;

	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_PENALTY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS_IN_USE   = 2'd2;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 24'd51200;
	localparam logic [PEN_W-1:0]    PENALTY_RESET = 16'd410;
	localparam logic [LIU_W-1:0]    LEVELS_RESET  = 11'd0;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SCAN,
		CS_DRAIN,
		CS_SEND
	} cell_state_t;

	typedef struct packed {
		logic                      req_type;
		logic [IDX_W-1:0]          entry_index;
		logic [LEVEL_W-1:0]        entry_level;
		logic [COST_W-1:0]         entry_cost;
		logic [VALUE_W-1:0]        query_value;
		logic [SCORE_W-1:0]        best_score;
		logic [TIDX_W-1:0]         best_index;
		logic [LEVEL_W-1:0]        best_level;
	} item_t;

endpackage
`default_nettype wire

FILE: rtl/core/plns_if.sv
// Request and result channel interfaces of the penalized nearest level search unit.
`default_nettype none
interface plns_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic [plns_pkg::IDX_W-1:0]           entry_index;
	logic signed [plns_pkg::LEVEL_W-1:0]  entry_level;
	logic [plns_pkg::COST_W-1:0]          entry_cost;
	logic signed [plns_pkg::VALUE_W-1:0]  query_value;

	modport source (output valid, output req_type, output entry_index, output entry_level,
		output entry_cost, output query_value, input ready);
	modport sink (input valid, input req_type, input entry_index, input entry_level,
		input entry_cost, input query_value, output ready);
endinterface

interface plns_res_if;
	logic                                 valid;
	logic                                 ready;
	logic [plns_pkg::IDX_W-1:0]           best_index;
	logic [plns_pkg::SCORE_W-1:0]         best_score;
	logic signed [plns_pkg::RES_W-1:0]    residual;
	logic                                 table_empty;

	modport source (output valid, output best_index, output best_score, output residual,
		output table_empty, input ready);
	modport sink (input valid, input best_index, input best_score, input residual,
		input table_empty, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/plns_cell.sv
// One level cell: a bank of table entries, its scoring pipeline and the running best.
`default_nettype none
module plns_cell (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [plns_pkg::CELL_W-1:0]     cell_id,
	input  wire logic [plns_pkg::CNT_W-1:0]      levels,
	input  wire logic [plns_pkg::WEIGHT_W-1:0]   weight,
	input  wire logic [plns_pkg::PEN_W-1:0]      penalty,
	input  wire logic                            up_valid,
	output      logic                            up_ready,
	input  wire plns_pkg::item_t                 up_item,
	output      logic                            dn_valid,
	input  wire logic                            dn_ready,
	output      plns_pkg::item_t                 dn_item
);

	plns_pkg::cell_state_t state_q, state_d;
	plns_pkg::item_t       item_q;
	logic [plns_pkg::BCNT_W-1:0] cnt_q;
	logic [plns_pkg::BANK_W-1:0] addr_q;

	logic [plns_pkg::CNT_W-1:0]  base;
	logic [plns_pkg::CNT_W-1:0]  idx_ext;
	logic [plns_pkg::CNT_W-1:0]  avail;
	logic [plns_pkg::BCNT_W-1:0] span;
	logic [plns_pkg::BANK_W-1:0] load_addr;
	logic                        load_hit;
	logic                        accept;
	logic                        rd_en;
	logic                        last_addr;
	logic                        pipe_busy;
	logic                        take_best;

	logic [plns_pkg::LEVEL_W+plns_pkg::COST_W-1:0] bank_mem [plns_pkg::BANK_DEPTH];

	logic                            v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [plns_pkg::LEVEL_W+plns_pkg::COST_W-1:0] rd_s1;
	logic [plns_pkg::TIDX_W-1:0]     gidx_s1, gidx_s2, gidx_s3, gidx_s4, gidx_s5;
	logic [plns_pkg::LEVEL_W-1:0]    lvl_s2, lvl_s3, lvl_s4, lvl_s5;
	logic [plns_pkg::ABS_W-1:0]      ad_s2;
	logic [plns_pkg::PENP_W-1:0]     pen_s2, pen_s3, pen_s4;
	logic [plns_pkg::SQ_W-1:0]       sq_s3;
	logic [plns_pkg::PROD_W-1:0]     dist_s4;
	logic [plns_pkg::SCORE_W-1:0]    score_s5;

	logic [plns_pkg::LEVEL_W-1:0]    lvl_rd;
	logic [plns_pkg::COST_W-1:0]     cost_rd;
	logic [plns_pkg::RES_W-1:0]      diff;
	logic [plns_pkg::RES_W-1:0]      diff_neg;
	logic [plns_pkg::SUM_W-1:0]      sum;

	assign base      = plns_pkg::CNT_W'(cell_id) * plns_pkg::CNT_W'(plns_pkg::BANK_DEPTH);
	assign idx_ext   = plns_pkg::CNT_W'(up_item.entry_index);
	assign load_hit  = (idx_ext >= base)
		&& (idx_ext < base + plns_pkg::CNT_W'(plns_pkg::BANK_DEPTH));
	assign load_addr = plns_pkg::BANK_W'(idx_ext - base);
	assign avail     = (levels > base) ? levels - base : '0;
	assign span      = (avail > plns_pkg::CNT_W'(plns_pkg::BANK_DEPTH))
		? plns_pkg::BCNT_W'(plns_pkg::BANK_DEPTH) : plns_pkg::BCNT_W'(avail);
	assign accept    = up_valid && up_ready;
	assign last_addr = (addr_q == plns_pkg::BANK_W'(cnt_q - 1'b1));
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign dn_item   = item_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			plns_pkg::CS_IDLE: begin
				if (up_valid) begin
					if (up_item.req_type == plns_pkg::REQ_QUERY && span != '0) begin
						state_d = plns_pkg::CS_SCAN;
					end else begin
						state_d = plns_pkg::CS_SEND;
					end
				end
			end
			plns_pkg::CS_SCAN: begin
				if (last_addr) begin
					state_d = plns_pkg::CS_DRAIN;
				end
			end
			plns_pkg::CS_DRAIN: begin
				if (!pipe_busy) begin
					state_d = plns_pkg::CS_SEND;
				end
			end
			plns_pkg::CS_SEND: begin
				if (dn_ready) begin
					state_d = plns_pkg::CS_IDLE;
				end
			end
			default: state_d = plns_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		up_ready = 1'b0;
		dn_valid = 1'b0;
		rd_en    = 1'b0;
		case (state_q)
			plns_pkg::CS_IDLE:  up_ready = 1'b1;
			plns_pkg::CS_SCAN:  rd_en    = 1'b1;
			plns_pkg::CS_DRAIN: ;
			plns_pkg::CS_SEND:  dn_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plns_pkg::CS_IDLE;
			cnt_q   <= '0;
			addr_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q  <= span;
				addr_q <= '0;
			end else if (rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && up_item.req_type == plns_pkg::REQ_LOAD && load_hit) begin
			bank_mem[load_addr] <= {up_item.entry_level, up_item.entry_cost};
		end
		if (rd_en) begin
			rd_s1 <= bank_mem[addr_q];
		end
	end

	assign lvl_rd   = rd_s1[plns_pkg::LEVEL_W+plns_pkg::COST_W-1:plns_pkg::COST_W];
	assign cost_rd  = rd_s1[plns_pkg::COST_W-1:0];
	assign diff     = {item_q.query_value[plns_pkg::VALUE_W-1], item_q.query_value}
		- {lvl_rd[plns_pkg::LEVEL_W-1], lvl_rd};
	assign diff_neg = ~diff + 1'b1;
	assign sum      = plns_pkg::SUM_W'(dist_s4)
		+ plns_pkg::SUM_W'({pen_s4, plns_pkg::PEN_SH'(0)});
	assign take_best = v_s5 && (gidx_s5 == '0 || score_s5 < item_q.best_score);

	always_ff @(posedge clk) begin
		gidx_s1 <= plns_pkg::TIDX_W'(base + plns_pkg::CNT_W'(addr_q));

		ad_s2   <= plns_pkg::ABS_W'(diff[plns_pkg::RES_W-1] ? diff_neg : diff);
		pen_s2  <= plns_pkg::PENP_W'(penalty) * plns_pkg::PENP_W'(cost_rd);
		lvl_s2  <= lvl_rd;
		gidx_s2 <= gidx_s1;

		sq_s3   <= plns_pkg::SQ_W'(ad_s2) * plns_pkg::SQ_W'(ad_s2);
		pen_s3  <= pen_s2;
		lvl_s3  <= lvl_s2;
		gidx_s3 <= gidx_s2;

		dist_s4 <= plns_pkg::PROD_W'(sq_s3) * plns_pkg::PROD_W'(weight);
		pen_s4  <= pen_s3;
		lvl_s4  <= lvl_s3;
		gidx_s4 <= gidx_s3;

		score_s5 <= (sum > plns_pkg::SUM_W'(plns_pkg::SCORE_MAX))
			? plns_pkg::SCORE_MAX : plns_pkg::SCORE_W'(sum);
		lvl_s5   <= lvl_s4;
		gidx_s5  <= gidx_s4;

		if (accept) begin
			item_q <= up_item;
		end else if (take_best) begin
			item_q.best_score <= score_s5;
			item_q.best_index <= gidx_s5;
			item_q.best_level <= lvl_s5;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/penalized_nearest_level_search_unit.sv
// Top level of the penalized nearest level search unit: configuration, cell chain, result stage.
// A query walks a chain of NUM_CELLS cells; each cell scans the in-use entries of its bank at one
// bank read per cycle, then drains its scoring pipeline before it passes the query on.
// A cell holds one item at a time and takes no new one until it has passed the last one on. A load
// passes through every cell, is written by the cell whose bank holds its index, and gives no result.
// Reset clears control state and sets the registers to their defaults; table entries stay
// undefined until loaded, with no clearing pass.
`default_nettype none
module penalized_nearest_level_search_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	plns_req_if.sink                                req,
	plns_res_if.source                              res,
	input  wire logic                               cfg_we,
	input  wire logic [plns_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [plns_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	logic [plns_pkg::WEIGHT_W-1:0] distance_weight_q;
	logic [plns_pkg::PEN_W-1:0]    height_penalty_q;
	logic [plns_pkg::LIU_W-1:0]    levels_in_use_q;
	logic [plns_pkg::CNT_W-1:0]    levels_clamped;

	plns_pkg::item_t link_item  [plns_pkg::NUM_CELLS+1];
	logic            link_valid [plns_pkg::NUM_CELLS+1];
	logic            link_ready [plns_pkg::NUM_CELLS+1];

	plns_pkg::item_t tail_item;
	logic            take_result;
	logic            out_v_q;
	logic [plns_pkg::IDX_W-1:0]   best_index_q;
	logic [plns_pkg::SCORE_W-1:0] best_score_q;
	logic [plns_pkg::RES_W-1:0]   residual_q;
	logic                         table_empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_weight_q <= plns_pkg::WEIGHT_RESET;
			height_penalty_q  <= plns_pkg::PENALTY_RESET;
			levels_in_use_q   <= plns_pkg::LEVELS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				plns_pkg::REG_DISTANCE_WEIGHT: distance_weight_q <= cfg_wdata;
				plns_pkg::REG_HEIGHT_PENALTY:
					height_penalty_q <= cfg_wdata[plns_pkg::PEN_W-1:0];
				plns_pkg::REG_LEVELS_IN_USE:
					levels_in_use_q <= cfg_wdata[plns_pkg::LIU_W-1:0];
				default: ;
			endcase
		end
	end

	assign levels_clamped = (plns_pkg::CNT_W'(levels_in_use_q)
		> plns_pkg::CNT_W'(plns_pkg::TABLE_DEPTH))
		? plns_pkg::CNT_W'(plns_pkg::TABLE_DEPTH) : plns_pkg::CNT_W'(levels_in_use_q);

	assign link_item[0]  = {req.req_type, req.entry_index, req.entry_level, req.entry_cost,
		req.query_value, plns_pkg::SCORE_MAX, plns_pkg::TIDX_W'(0), plns_pkg::LEVEL_W'(0)};
	assign link_valid[0] = req.valid;
	assign req.ready     = link_ready[0];

	for (genvar i = 0; i < plns_pkg::NUM_CELLS; i++) begin : g_cell
		plns_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_id  (plns_pkg::CELL_W'(i)),
			.levels   (levels_clamped),
			.weight   (distance_weight_q),
			.penalty  (height_penalty_q),
			.up_valid (link_valid[i]),
			.up_ready (link_ready[i]),
			.up_item  (link_item[i]),
			.dn_valid (link_valid[i+1]),
			.dn_ready (link_ready[i+1]),
			.dn_item  (link_item[i+1])
		);
	end

	// drop loads at the tail; queries wait for the result stage
	assign tail_item = link_item[plns_pkg::NUM_CELLS];
	assign link_ready[plns_pkg::NUM_CELLS] = (tail_item.req_type == plns_pkg::REQ_LOAD)
		|| !out_v_q || res.ready;
	assign take_result = link_valid[plns_pkg::NUM_CELLS] && link_ready[plns_pkg::NUM_CELLS]
		&& (tail_item.req_type == plns_pkg::REQ_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (take_result) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_result) begin
			table_empty_q <= (levels_clamped == '0);
			if (levels_clamped == '0) begin
				best_index_q <= '0;
				best_score_q <= plns_pkg::SCORE_MAX;
				residual_q   <= '0;
			end else begin
				best_index_q <= plns_pkg::IDX_W'(tail_item.best_index);
				best_score_q <= tail_item.best_score;
				residual_q   <= {tail_item.query_value[plns_pkg::VALUE_W-1], tail_item.query_value}
					- {tail_item.best_level[plns_pkg::LEVEL_W-1], tail_item.best_level};
			end
		end
	end

	assign res.valid       = out_v_q;
	assign res.best_index  = best_index_q;
	assign res.best_score  = best_score_q;
	assign res.residual    = residual_q;
	assign res.table_empty = table_empty_q;

endmodule
`default_nettype wire
